// ----- design/xrrg_pkg.sv -----
// ----------------------------------------------------------------------------
// xrrg_pkg: shared types and constants of the xorwow ranged generator
// Field widths, command codes, register indexes and seed reset values.
// ----------------------------------------------------------------------------
package xrrg_pkg;

   // field widths
   localparam int WORD_W = 32;
   localparam int CMD_W  = 3;
   localparam int THR_W  = WORD_W + 1;
   localparam int CSR_IDX_W = 2;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [THR_W-1:0]     thr_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // request commands
   localparam cmd_type CMD_RESEED = 3'd0;
   localparam cmd_type CMD_RAW    = 3'd1;
   localparam cmd_type CMD_URANGE = 3'd2;
   localparam cmd_type CMD_SRANGE = 3'd3;
   localparam cmd_type CMD_CHANCE = 3'd4;

   // seed register indexes
   localparam csr_idx_type CSR_SEED_FIRST  = 2'd0;
   localparam csr_idx_type CSR_SEED_SECOND = 2'd1;
   localparam csr_idx_type CSR_SEED_THIRD  = 2'd2;
   localparam csr_idx_type CSR_SEED_FOURTH = 2'd3;

   // seed reset values
   localparam word_type SEED_FIRST_RST  = 32'd123456789;
   localparam word_type SEED_SECOND_RST = 32'd362436069;
   localparam word_type SEED_THIRD_RST  = 32'd521288629;
   localparam word_type SEED_FOURTH_RST = 32'd88675123;

   // weyl counter increment and sign bias for signed bound compare
   localparam word_type WEYL_STEP = 32'd362437;
   localparam word_type SIGN_BIT  = 32'h8000_0000;

endpackage

// ----- design/xrrg_req_if.sv -----
// ----------------------------------------------------------------------------
// xrrg_req_if: request channel of the xorwow ranged generator
// Valid/ready handshake carrying command, range bounds and chance threshold.
// ----------------------------------------------------------------------------
interface xrrg_req_if;
   import xrrg_pkg::*;

   logic     valid;
   logic     ready;
   cmd_type  command;
   word_type range_low;
   word_type range_high;
   thr_type  threshold;

   modport source (output valid, output command, output range_low,
                   output range_high, output threshold, input ready);
   modport sink   (input valid, input command, input range_low,
                   input range_high, input threshold, output ready);
endinterface

// ----- design/xrrg_rsp_if.sv -----
// ----------------------------------------------------------------------------
// xrrg_rsp_if: response channel of the xorwow ranged generator
// Valid/ready handshake carrying the result word and the chance hit flag.
// ----------------------------------------------------------------------------
interface xrrg_rsp_if;
   import xrrg_pkg::*;

   logic     valid;
   logic     ready;
   word_type value;
   logic     hit;

   modport source (output valid, output value, output hit, input ready);
   modport sink   (input valid, input value, input hit, output ready);
endinterface

// ----- design/xorwow_ranged_random_generator.sv -----
// ----------------------------------------------------------------------------
// xorwow_ranged_random_generator: xorwow generator with range and chance draws
// One request at a time; each request yields exactly one response.
// ----------------------------------------------------------------------------
// Each request passes from acceptance through the step state to the finish
// state, where the response register is loaded, except a range draw over a
// span that is neither a single value nor the full 32-bit range, which passes
// through the divide state: the remainder is worked out by one 33-bit
// subtract-and-compare unit, one quotient bit per cycle. The next request is taken
// as soon as the response register is loaded, even while that response still
// waits; a finished result waits only if the previous response is still held.
// Seed registers may be written at any time and take effect at the next
// reseed request. There is no clearing pass after reset.
module xorwow_ranged_random_generator (
   input  logic                  clock,
   input  logic                  reset,
   xrrg_req_if.sink              req_bus,
   xrrg_rsp_if.source            rsp_bus,
   input  logic                  csr_write_en,
   input  xrrg_pkg::csr_idx_type csr_index,
   input  xrrg_pkg::word_type    csr_data
);
   import xrrg_pkg::*;

   localparam int CNT_W = $clog2(WORD_W);

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_STEP   = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;

   // seed registers
   word_type seed_first_ff, seed_second_ff, seed_third_ff, seed_fourth_ff;

   // generator state; weyl_ahead_ff holds the counter already stepped once
   word_type word_a_ff, word_b_ff, word_c_ff, word_d_ff, weyl_ahead_ff;
   word_type word_a_in, word_b_in, word_c_in, word_d_in, weyl_ahead_in;

   // request working registers
   cmd_type  cmd_ff, cmd_in;
   word_type lo_ff, lo_in, hi_ff, hi_in;
   thr_type  thr_ff, thr_in;
   word_type span_ff, span_in;
   word_type work_ff, work_in;
   word_type rem_ff, rem_in;
   word_type div_ff, div_in;
   logic     add_lo_ff, add_lo_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // response register
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_value_ff, rsp_value_in;
   logic     rsp_hit_ff, rsp_hit_in;

   // bound ordering at request acceptance
   word_type bias;
   logic     swap;
   logic     req_fire;

   // xorwow step
   word_type t_shr, t_shl, t_new, draw;

   // range span of the ordered bounds, zero when it covers all 32 bits
   word_type span_calc;

   // shared divide unit
   logic [WORD_W:0] trial, diff;

   // finish stage
   word_type fin_value;
   logic     fin_hit;
   logic     rsp_free;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && (state_ff == ST_IDLE);

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.value = rsp_value_ff;
   assign rsp_bus.hit   = rsp_hit_ff;

   // signed bounds compare as unsigned after flipping the sign bit
   assign bias = (req_bus.command == CMD_SRANGE) ? SIGN_BIT : '0;
   assign swap = (req_bus.range_low ^ bias) > (req_bus.range_high ^ bias);

   // next word from current state
   assign t_shr = word_d_ff ^ (word_d_ff >> 2);
   assign t_shl = t_shr ^ (t_shr << 1);
   assign t_new = t_shl ^ word_a_ff ^ (word_a_ff << 4);
   assign draw  = t_new + weyl_ahead_ff;

   // span of the ordered bounds
   assign span_calc = hi_ff - lo_ff + 32'd1;

   // one restoring remainder step
   assign trial = {rem_ff, div_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, span_ff};

   // result selection and chance compare
   assign fin_value = add_lo_ff ? (rem_ff + lo_ff) : work_ff;
   assign fin_hit   = (cmd_ff == CMD_CHANCE) && ({1'b0, work_ff} < thr_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;

   // sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      word_a_in     = word_a_ff;
      word_b_in     = word_b_ff;
      word_c_in     = word_c_ff;
      word_d_in     = word_d_ff;
      weyl_ahead_in = weyl_ahead_ff;
      cmd_in        = cmd_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      thr_in        = thr_ff;
      span_in       = span_ff;
      work_in       = work_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      add_lo_in     = add_lo_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_hit_in    = rsp_hit_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_bus.command;
               lo_in    = swap ? req_bus.range_high : req_bus.range_low;
               hi_in    = swap ? req_bus.range_low : req_bus.range_high;
               thr_in   = req_bus.threshold;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            work_in   = '0;
            add_lo_in = 1'b0;
            span_in   = span_calc;
            state_in  = ST_FINISH;
            case (cmd_ff) inside
               CMD_RESEED: begin
                  word_a_in     = seed_first_ff;
                  word_b_in     = seed_second_ff;
                  word_c_in     = seed_third_ff;
                  word_d_in     = seed_fourth_ff;
                  weyl_ahead_in = WEYL_STEP;
               end
               CMD_RAW, CMD_CHANCE: begin
                  word_a_in     = t_new;
                  word_b_in     = word_a_ff;
                  word_c_in     = word_b_ff;
                  word_d_in     = word_c_ff;
                  weyl_ahead_in = weyl_ahead_ff + WEYL_STEP;
                  work_in       = draw;
               end
               CMD_URANGE, CMD_SRANGE: begin
                  if (lo_ff == hi_ff) begin
                     // single-value range: no draw
                     work_in = lo_ff;
                  end else begin
                     word_a_in     = t_new;
                     word_b_in     = word_a_ff;
                     word_c_in     = word_b_ff;
                     word_d_in     = word_c_ff;
                     weyl_ahead_in = weyl_ahead_ff + WEYL_STEP;
                     work_in       = draw;
                     // full 32-bit span returns the raw draw
                     if (span_calc != '0) begin
                        div_in    = draw;
                        rem_in    = '0;
                        add_lo_in = 1'b1;
                        count_in  = CNT_W'(WORD_W - 1);
                        state_in  = ST_DIV;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_DIV: begin
            rem_in   = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
            div_in   = div_ff << 1;
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = fin_value;
               rsp_hit_in   = fin_hit;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         seed_first_ff  <= SEED_FIRST_RST;
         seed_second_ff <= SEED_SECOND_RST;
         seed_third_ff  <= SEED_THIRD_RST;
         seed_fourth_ff <= SEED_FOURTH_RST;
         word_a_ff      <= SEED_FIRST_RST;
         word_b_ff      <= SEED_SECOND_RST;
         word_c_ff      <= SEED_THIRD_RST;
         word_d_ff      <= SEED_FOURTH_RST;
         weyl_ahead_ff  <= WEYL_STEP;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         word_a_ff     <= word_a_in;
         word_b_ff     <= word_b_in;
         word_c_ff     <= word_c_in;
         word_d_ff     <= word_d_in;
         weyl_ahead_ff <= weyl_ahead_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_SEED_FIRST:  seed_first_ff  <= csr_data;
               CSR_SEED_SECOND: seed_second_ff <= csr_data;
               CSR_SEED_THIRD:  seed_third_ff  <= csr_data;
               CSR_SEED_FOURTH: seed_fourth_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      thr_ff       <= thr_in;
      span_ff      <= span_in;
      work_ff      <= work_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      add_lo_ff    <= add_lo_in;
      count_ff     <= count_in;
      rsp_value_ff <= rsp_value_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   // remainder stays below the span while dividing
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (span_ff != '0) && (rem_ff < span_ff))
      else $error("remainder not below span during division");

   // ranged result only finishes with a reduced remainder
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && add_lo_ff) |-> (rem_ff < span_ff))
      else $error("ranged result finishes with unreduced remainder");

   // division runs until its counter expires
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && count_ff != '0) |=> (state_ff == ST_DIV))
      else $error("division left early");

   // a response is only produced from the finish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside finish step");

   // a held response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready && state_ff == ST_FINISH) |=>
         (state_ff == ST_FINISH))
      else $error("finish step left while response still held");

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the xorwow ranged random generator
// Drives reseed, raw, range, chance and undefined-command requests with random idling on both
// channels and checks every response against an in-bench xorwow predictor.
// ----------------------------------------------------------------------------
module testbench;
   import xrrg_pkg::*;

   localparam cmd_type  CMD_LAST    = '1;
   localparam thr_type  THR_FULL    = {1'b1, {WORD_W{1'b0}}};
   localparam int       STALL_LIMIT = 5000;
   localparam int       SEG_ITEMS   = 300;
   localparam int       SEG_COUNT   = 6;
   localparam int       TAIL_CYCLES = 40;
   localparam int       REPORT_MAX  = 100;

   typedef struct packed {
      word_type value;
      logic     hit;
   } draw_result_type;

   // predictor of the generator plus the queue of outstanding results
   class draw_scoreboard;
      word_type        seeds [4];
      word_type        shift [4];
      word_type        weyl_sum;
      draw_result_type expected_draws [$];
      int              mismatches;

      function new();
         seeds[CSR_SEED_FIRST]  = SEED_FIRST_RST;
         seeds[CSR_SEED_SECOND] = SEED_SECOND_RST;
         seeds[CSR_SEED_THIRD]  = SEED_THIRD_RST;
         seeds[CSR_SEED_FOURTH] = SEED_FOURTH_RST;
         mismatches = 0;
         reload_state();
      endfunction

      function void reload_state();
         for (int i = 0; i < 4; i++) shift[i] = seeds[i];
         weyl_sum = '0;
      endfunction

      function void set_seed(csr_idx_type idx, word_type data);
         seeds[idx] = data;
      endfunction

      // one xorwow step, returns the new first word plus the weyl sum
      function word_type step_generator();
         word_type t, s;
         t = shift[3];
         s = shift[0];
         shift[3] = shift[2];
         shift[2] = shift[1];
         shift[1] = s;
         t = t ^ (t >> 2);
         t = t ^ (t << 1);
         t = t ^ s ^ (s << 4);
         shift[0] = t;
         weyl_sum = weyl_sum + WEYL_STEP;
         return t + weyl_sum;
      endfunction

      // bounded draw with ordering, equal bounds and full span handling
      function word_type ranged_draw(word_type lo, word_type hi, bit signed_cmp);
         word_type bias, span, draw, tmp;
         bias = signed_cmp ? SIGN_BIT : '0;
         if (lo == hi) return lo;
         if ((lo ^ bias) > (hi ^ bias)) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
         end
         span = hi - lo + 1;
         draw = step_generator();
         if (span == '0) return draw;
         return draw % span + lo;
      endfunction

      function draw_result_type predict_draw(cmd_type cmd, word_type lo, word_type hi,
                                             thr_type thr);
         draw_result_type r;
         r = '0;
         case (cmd)
            CMD_RESEED: begin
               reload_state();
            end
            CMD_RAW: begin
               r.value = step_generator();
            end
            CMD_URANGE: begin
               r.value = ranged_draw(lo, hi, 1'b0);
            end
            CMD_SRANGE: begin
               r.value = ranged_draw(lo, hi, 1'b1);
            end
            CMD_CHANCE: begin
               r.value = step_generator();
               r.hit   = ({1'b0, r.value} < thr);
            end
            default: begin
            end
         endcase
         return r;
      endfunction

      function void note_request(cmd_type cmd, word_type lo, word_type hi,
                                 thr_type thr);
         expected_draws.push_back(predict_draw(cmd, lo, hi, thr));
      endfunction

      task report(string msg);
         if (mismatches < REPORT_MAX) $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_response(word_type value, logic hit);
         draw_result_type exp_r;
         if (expected_draws.size() == 0) begin
            report($sformatf("response %h/%b with no request outstanding", value, hit));
         end else begin
            exp_r = expected_draws.pop_front();
            if (value !== exp_r.value)
               report($sformatf("value got %h, predicted %h", value, exp_r.value));
            if (hit !== exp_r.hit)
               report($sformatf("hit got %b, predicted %b", hit, exp_r.hit));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   csr_idx_type csr_index;
   word_type    csr_data;

   xrrg_req_if req ();
   xrrg_rsp_if rsp ();

   draw_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_cycles;

   xorwow_ranged_random_generator u_top (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req),
      .rsp_bus      (rsp),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #1 clock = ~clock;

   // receiver stalls
   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // handshake monitor and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            board.note_request(req.command, req.range_low, req.range_high,
                               req.threshold);
         if (rsp.valid && rsp.ready)
            board.check_response(rsp.value, rsp.hit);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

   // one request, with random sender gaps carrying junk fields
   task automatic send_request(cmd_type cmd, word_type lo, word_type hi, thr_type thr);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid      <= 1'b0;
         req.command    <= cmd_type'($urandom);
         req.range_low  <= $urandom;
         req.range_high <= $urandom;
         req.threshold  <= {1'($urandom_range(0, 1)), word_type'($urandom)};
         @(negedge clock);
      end
      req.valid      <= 1'b1;
      req.command    <= cmd;
      req.range_low  <= lo;
      req.range_high <= hi;
      req.threshold  <= thr;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   function automatic word_type pick_bound();
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return '1;
               2: return SIGN_BIT;
               default: return ~SIGN_BIT;
            endcase
         end
         1: return $urandom_range(0, 1) ? word_type'($urandom_range(0, 20))
                                        : -word_type'($urandom_range(1, 20));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_request();
      int       pick;
      cmd_type  cmd;
      word_type lo, hi, tmp;
      thr_type  thr;
      pick = $urandom_range(0, 99);
      if (pick < 5)       cmd = CMD_RESEED;
      else if (pick < 20) cmd = CMD_RAW;
      else if (pick < 50) cmd = CMD_URANGE;
      else if (pick < 75) cmd = CMD_SRANGE;
      else if (pick < 95) cmd = CMD_CHANCE;
      else                cmd = cmd_type'($urandom_range(CMD_CHANCE + 1, CMD_LAST));
      lo = pick_bound();
      case ($urandom_range(0, 5))
         0: hi = lo;
         1, 2: hi = lo + word_type'($urandom_range(1, 1000));
         3: begin
            // full span for the comparison the command uses
            lo = (cmd == CMD_SRANGE) ? SIGN_BIT : '0;
            hi = lo - 1;
         end
         default: hi = pick_bound();
      endcase
      if ($urandom_range(0, 1)) begin
         tmp = lo;
         lo  = hi;
         hi  = tmp;
      end
      case ($urandom_range(0, 5))
         0: thr = '0;
         1: thr = THR_FULL;
         2: thr = {1'b1, word_type'($urandom)};
         default: thr = {1'b0, word_type'($urandom)};
      endcase
      send_request(cmd, lo, hi, thr);
   endtask

   // wait until every predicted response has come back
   task automatic wait_for_drain();
      req.valid <= 1'b0;
      do @(negedge clock); while (board.expected_draws.size() != 0);
   endtask

   task automatic write_csr(csr_idx_type idx, word_type data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      board.set_seed(idx, data);
      @(negedge clock);
   endtask

   // seed settings per segment: extremes, random, mixed, back to reset
   task automatic load_seed_set(int set_no);
      word_type s0, s1, s2, s3;
      case (set_no)
         0: begin s0 = '0; s1 = '0; s2 = '0; s3 = '0; end
         1: begin s0 = '1; s1 = '1; s2 = '1; s3 = '1; end
         3: begin s0 = '0; s1 = '1; s2 = SIGN_BIT; s3 = $urandom; end
         5: begin
            s0 = SEED_FIRST_RST;
            s1 = SEED_SECOND_RST;
            s2 = SEED_THIRD_RST;
            s3 = SEED_FOURTH_RST;
         end
         default: begin s0 = $urandom; s1 = $urandom; s2 = $urandom; s3 = $urandom; end
      endcase
      write_csr(CSR_SEED_FIRST, s0);
      write_csr(CSR_SEED_SECOND, s1);
      write_csr(CSR_SEED_THIRD, s2);
      write_csr(CSR_SEED_FOURTH, s3);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      req.valid      = 1'b0;
      req.command    = CMD_RAW;
      req.range_low  = '0;
      req.range_high = '0;
      req.threshold  = '0;
      rsp.ready      = 1'b0;
      stall_cycles   = 0;
      send_idle_pct  = 12;
      recv_idle_pct  = 68;
      board          = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset seeds, chance thresholds, range corner cases
      send_request(CMD_RAW, '0, '0, '0);
      send_request(CMD_RAW, '1, '1, '1);
      send_request(CMD_CHANCE, '0, '0, '0);
      send_request(CMD_CHANCE, '0, '0, THR_FULL);
      send_request(CMD_CHANCE, '0, '0, '1);
      send_request(CMD_CHANCE, '0, '0, {1'b0, {WORD_W{1'b1}}});
      send_request(CMD_RESEED, '1, '1, '1);
      send_request(CMD_RAW, '0, '0, '0);
      send_request(CMD_URANGE, '0, '0, '0);
      send_request(CMD_URANGE, '1, '1, '0);
      send_request(CMD_URANGE, '0, '1, '0);
      send_request(CMD_URANGE, '1, '0, '0);
      send_request(CMD_URANGE, 32'd100, 32'd10, '0);
      send_request(CMD_URANGE, '0, 32'd1, '0);
      send_request(CMD_URANGE, 32'hFFFF_FFFE, '1, '0);
      send_request(CMD_SRANGE, SIGN_BIT, ~SIGN_BIT, '0);
      send_request(CMD_SRANGE, ~SIGN_BIT, SIGN_BIT, '0);
      send_request(CMD_SRANGE, 32'd5, -32'sd3, '0);
      send_request(CMD_SRANGE, -32'sd10, 32'd10, '0);
      send_request(CMD_SRANGE, SIGN_BIT, SIGN_BIT, '0);
      send_request(cmd_type'(CMD_CHANCE + 1), '1, '1, '1);
      send_request(cmd_type'(CMD_CHANCE + 2), '0, '0, '0);
      send_request(CMD_LAST, '1, '0, THR_FULL);
      send_request(CMD_RESEED, '0, '0, '0);

      // random segments, each after a fresh seed setting
      for (int seg = 0; seg < SEG_COUNT; seg++) begin
         wait_for_drain();
         if (seg == 2) begin
            send_idle_pct = 68;
            recv_idle_pct = 12;
         end else if (seg == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         load_seed_set(seg);
         send_request(CMD_RESEED, $urandom, $urandom, '0);
         repeat (SEG_ITEMS) send_random_request();
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/xrrg_pkg.sv
design/xrrg_req_if.sv
design/xrrg_rsp_if.sv
design/xorwow_ranged_random_generator.sv
verif/testbench.sv
